// ----- rtl/column_delta_row_encoder_assert.svh -----
// Assertion macros shared by the encoder modules.
`ifndef COLUMN_DELTA_ROW_ENCODER_ASSERT_SVH
`define COLUMN_DELTA_ROW_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define CDRE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CDRE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cdre_pkg.sv -----
// Shared types and constants of the column delta row encoder.
`default_nettype none
package cdre_pkg;

   localparam int MAX_COLUMNS_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [4:0]  NUM_COLUMNS_RESET      = 5'd1;
   localparam logic [15:0] REFRESH_INTERVAL_RESET = 16'd0;
   localparam logic [12:0] SMALL_DELTA_MAX_RESET  = 13'h1FFF;
   localparam logic [20:0] MEDIUM_DELTA_MAX_RESET = 21'h1FFFFF;

   localparam logic [7:0] RAW_TOP_MASK  = 8'h7F;
   localparam logic       DELTA_MARK    = 1'b1;
   localparam logic       SMALL_FORMAT  = 1'b0;
   localparam logic       MEDIUM_FORMAT = 1'b1;

   typedef enum logic [1:0] {
      REG_NUM_COLUMNS      = 2'd0,
      REG_REFRESH_INTERVAL = 2'd1,
      REG_SMALL_DELTA_MAX  = 2'd2,
      REG_MEDIUM_DELTA_MAX = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_SMALL  = 2'd0,
      KIND_MEDIUM = 2'd1,
      KIND_RAW    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [4:0]  num_columns;
      logic [15:0] refresh_interval;
      logic [12:0] small_delta_max;
      logic [20:0] medium_delta_max;
   } cfg_type;

   // one classified word: raw value or delta magnitude
   typedef struct packed {
      kind_type    kind;
      logic        sign;
      logic [31:0] data;
   } entry_type;

endpackage
`default_nettype wire

// ----- rtl/cdre_csr.sv -----
// Configuration registers behind the APB-style port.
`default_nettype none
module cdre_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [3:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready,
   output cdre_pkg::cfg_type     cfg
);

   cdre_pkg::cfg_type       cfg_ff;
   cdre_pkg::reg_index_type index;
   logic                    write_en;

   assign index      = cdre_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_columns      <= cdre_pkg::NUM_COLUMNS_RESET;
         cfg_ff.refresh_interval <= cdre_pkg::REFRESH_INTERVAL_RESET;
         cfg_ff.small_delta_max  <= cdre_pkg::SMALL_DELTA_MAX_RESET;
         cfg_ff.medium_delta_max <= cdre_pkg::MEDIUM_DELTA_MAX_RESET;
      end else if (write_en) begin
         case (index)
            cdre_pkg::REG_NUM_COLUMNS:      cfg_ff.num_columns      <= csr_pwdata[4:0];
            cdre_pkg::REG_REFRESH_INTERVAL: cfg_ff.refresh_interval <= csr_pwdata[15:0];
            cdre_pkg::REG_SMALL_DELTA_MAX:  cfg_ff.small_delta_max  <= csr_pwdata[12:0];
            cdre_pkg::REG_MEDIUM_DELTA_MAX: cfg_ff.medium_delta_max <= csr_pwdata[20:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         cdre_pkg::REG_NUM_COLUMNS:      csr_prdata = {27'd0, cfg_ff.num_columns};
         cdre_pkg::REG_REFRESH_INTERVAL: csr_prdata = {16'd0, cfg_ff.refresh_interval};
         cdre_pkg::REG_SMALL_DELTA_MAX:  csr_prdata = {19'd0, cfg_ff.small_delta_max};
         cdre_pkg::REG_MEDIUM_DELTA_MAX: csr_prdata = {11'd0, cfg_ff.medium_delta_max};
         default:                        csr_prdata = 32'd0;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/cdre_front.sv -----
// Front end: column tracking, raw/delta decision and delta classification.
`default_nettype none
module cdre_front #(
   parameter int MAX_COLUMNS = cdre_pkg::MAX_COLUMNS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  cdre_pkg::cfg_type       cfg,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [31:0]        req_tdata,
   output logic                    push,
   output cdre_pkg::entry_type     push_data,
   input  wire logic               queue_full
);

   // num_columns cannot exceed 31, so no more entries are ever addressed
   localparam int DEPTH = (MAX_COLUMNS < 31) ? MAX_COLUMNS : 31;
   localparam int CW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [31:0]   prev_ff [DEPTH];
   logic [CW-1:0] col_ff, col_in;
   logic          raw_ff;
   logic          primed_ff, primed_in;
   logic [15:0]   rows_ff, rows_in;

   logic [4:0]    n_eff;
   logic [CW-1:0] col;
   logic          raw_mode;
   logic          row_end;
   logic [31:0]   last;
   logic          add;
   logic [31:0]   mag;
   logic          accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept;

   always_comb begin
      n_eff = cfg.num_columns;
      if (n_eff == 5'd0)
         n_eff = 5'd1;
      if (6'(n_eff) > 6'(DEPTH))
         n_eff = 5'(DEPTH);
   end

   always_comb begin
      col = (6'(col_ff) >= 6'(n_eff)) ? '0 : col_ff;
      if (col == '0) begin
         raw_mode = !primed_ff ||
                    ((cfg.refresh_interval != 16'd0) && (rows_ff >= cfg.refresh_interval));
      end else begin
         raw_mode = raw_ff;
      end
      last = prev_ff[col];
      add  = (req_tdata >= last);
      mag  = add ? (req_tdata - last) : (last - req_tdata);

      push_data.sign = add;
      if (raw_mode) begin
         push_data.kind = cdre_pkg::KIND_RAW;
         push_data.data = req_tdata;
      end else if (mag <= {19'd0, cfg.small_delta_max}) begin
         push_data.kind = cdre_pkg::KIND_SMALL;
         push_data.data = mag;
      end else if (mag <= {11'd0, cfg.medium_delta_max}) begin
         push_data.kind = cdre_pkg::KIND_MEDIUM;
         push_data.data = mag;
      end else begin
         push_data.kind = cdre_pkg::KIND_RAW;
         push_data.data = req_tdata;
      end

      row_end   = (6'(col) + 6'd1) >= 6'(n_eff);
      col_in    = row_end ? '0 : CW'(6'(col) + 6'd1);
      primed_in = primed_ff;
      rows_in   = rows_ff;
      if (row_end) begin
         if (raw_mode) begin
            rows_in   = 16'd0;
            primed_in = 1'b1;
         end else if (rows_ff != 16'hFFFF) begin
            rows_in = rows_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         raw_ff    <= 1'b0;
         primed_ff <= 1'b0;
         rows_ff   <= 16'd0;
      end else if (accept) begin
         col_ff    <= col_in;
         raw_ff    <= raw_mode;
         primed_ff <= primed_in;
         rows_ff   <= rows_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         prev_ff[col] <= req_tdata;
   end

endmodule
`default_nettype wire

// ----- rtl/cdre_fifo.sv -----
// Short queue of classified words between front and back.
`default_nettype none
`include "column_delta_row_encoder_assert.svh"
module cdre_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  cdre_pkg::entry_type     push_data,
   output logic                    full,
   input  wire logic               pop,
   output cdre_pkg::entry_type     pop_data,
   output logic                    not_empty
);

   localparam int DEPTH = cdre_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);
   localparam logic [CNTW-1:0] ONE = CNTW'(1);

   cdre_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0]       wr_ff, rd_ff;
   logic [CNTW-1:0]     count_ff, count_in;

   assign full      = (count_ff == CNTW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)
         count_in = count_ff + ONE;
      else if (pop && !push)
         count_in = count_ff - ONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push)
            wr_ff <= wr_ff + PW'(1);
         if (pop)
            rd_ff <= rd_ff + PW'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ff] <= push_data;
   end

   `CDRE_ASSERT_IMPLY(a_no_push_full, clock, reset, full, !push, "push into full queue")
   `CDRE_ASSERT_IMPLY(a_no_pop_empty, clock, reset, !not_empty, !pop, "pop from empty queue")
   `CDRE_ASSERT_NEXT(a_pop_count, clock, reset, pop && !push, count_ff == $past(count_ff) - ONE, "queue count did not drop on pop")

endmodule
`default_nettype wire

// ----- rtl/cdre_back.sv -----
// Back end: turns one classified word into its output bytes.
`default_nettype none
`include "column_delta_row_encoder_assert.svh"
module cdre_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               not_empty,
   input  cdre_pkg::entry_type     pop_data,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast
);

   cdre_pkg::entry_type cur_ff;
   logic                valid_ff;
   logic [1:0]          idx_ff;
   logic [1:0]          last_idx;
   logic                fire;

   assign rsp_tvalid = valid_ff;
   assign fire       = valid_ff && rsp_tready;
   assign rsp_tlast  = (idx_ff == last_idx);
   assign pop        = not_empty && (!valid_ff || (fire && rsp_tlast));

   always_comb begin
      case (cur_ff.kind)
         cdre_pkg::KIND_SMALL: begin
            last_idx = 2'd1;
            case (idx_ff)
               2'd0:    rsp_tdata = {cdre_pkg::DELTA_MARK, cur_ff.sign,
                                     cdre_pkg::SMALL_FORMAT, cur_ff.data[12:8]};
               default: rsp_tdata = cur_ff.data[7:0];
            endcase
         end
         cdre_pkg::KIND_MEDIUM: begin
            last_idx = 2'd2;
            case (idx_ff)
               2'd0:    rsp_tdata = {cdre_pkg::DELTA_MARK, cur_ff.sign,
                                     cdre_pkg::MEDIUM_FORMAT, cur_ff.data[20:16]};
               2'd1:    rsp_tdata = cur_ff.data[15:8];
               default: rsp_tdata = cur_ff.data[7:0];
            endcase
         end
         default: begin
            last_idx = 2'd3;
            case (idx_ff)
               2'd0:    rsp_tdata = cur_ff.data[31:24] & cdre_pkg::RAW_TOP_MASK;
               2'd1:    rsp_tdata = cur_ff.data[23:16];
               2'd2:    rsp_tdata = cur_ff.data[15:8];
               default: rsp_tdata = cur_ff.data[7:0];
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (pop) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (fire) begin
         if (rsp_tlast) begin
            valid_ff <= 1'b0;
            idx_ff   <= 2'd0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop)
         cur_ff <= pop_data;
   end

   `CDRE_ASSERT_IMPLY(a_small_len, clock, reset, valid_ff && cur_ff.kind == cdre_pkg::KIND_SMALL, idx_ff <= 2'd1, "small delta past second byte")
   `CDRE_ASSERT_IMPLY(a_medium_len, clock, reset, valid_ff && cur_ff.kind == cdre_pkg::KIND_MEDIUM, idx_ff <= 2'd2, "medium delta past third byte")
   `CDRE_ASSERT_NEXT(a_byte_step, clock, reset, fire && !rsp_tlast, valid_ff && idx_ff == $past(idx_ff) + 2'd1, "byte index did not advance")

endmodule
`default_nettype wire

// ----- rtl/column_delta_row_encoder.sv -----
// Top level of the column delta row encoder.
//
//  channel   dir  handshake              payload
//  req_      in   req_tvalid/req_tready  req_tdata[31:0] = sample_value
//  rsp_      out  rsp_tvalid/rsp_tready  rsp_tdata[7:0] = out_byte, rsp_tlast = item_last
//  csr_      in   psel/penable, pready=1 regs at 0x0,0x4,0x8,0xC
//
// A sample yields 2, 3 or 4 output bytes, sent one by one through the byte-wide
// output port. The front classifies one sample per cycle into a 4-word queue
// while the queue is not full. Reset is synchronous; no clearing pass. Output
// stalls back up through the queue to req_tready only once the queue is full.
`default_nettype none
module column_delta_row_encoder #(
   parameter int MAX_COLUMNS = cdre_pkg::MAX_COLUMNS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] sample_value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cdre_pkg::cfg_type   cfg;
   cdre_pkg::entry_type push_data;
   cdre_pkg::entry_type pop_data;
   logic                push;
   logic                pop;
   logic                queue_full;
   logic                not_empty;

   cdre_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cdre_front #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   cdre_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (not_empty)
   );

   cdre_back u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (not_empty),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- bench/tb_column_delta_row_encoder.sv -----
// Bench for the column delta row encoder: directed table, then random phases.
`timescale 1ns / 100ps
module tb_column_delta_row_encoder;

   localparam int STALL_LIMIT = 5000;
   localparam int LONG_HOLD = 300;
   localparam int PHASE_WORDS = 42;
   localparam int FINAL_WORDS = 20;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } coded_byte_type;

   typedef struct {
      logic [31:0] sample;
      int          nbytes;   // 0: take the predicted bytes
      logic [31:0] coded;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   cdre_pkg::cfg_type model_cfg = '{cdre_pkg::NUM_COLUMNS_RESET,
                                    cdre_pkg::REFRESH_INTERVAL_RESET,
                                    cdre_pkg::SMALL_DELTA_MAX_RESET,
                                    cdre_pkg::MEDIUM_DELTA_MAX_RESET};
   logic [31:0] prev_col [cdre_pkg::MAX_COLUMNS_DEFAULT];
   logic        is_primed = 1'b0;
   logic        raw_row = 1'b0;
   logic [15:0] delta_rows = '0;
   int          col_at = 0;

   coded_byte_type bytes_due [$];
   int          mismatches = 0;
   bit          tx_idle_on = 1'b1;
   bit          rx_idle_on = 1'b1;
   int          long_hold_requests = 0;

   column_delta_row_encoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [31:0] sample_value
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [7:0] out_byte
      .rsp_tlast   (rsp_tlast),    // item_last
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic int active_columns();
      if (model_cfg.num_columns == 0) return 1;
      if (model_cfg.num_columns > cdre_pkg::MAX_COLUMNS_DEFAULT)
         return cdre_pkg::MAX_COLUMNS_DEFAULT;
      return int'(model_cfg.num_columns);
   endfunction

   function automatic void encode_sample(input logic [31:0] v, output logic [31:0] coded,
                                         output int nbytes);
      int                 n;
      int                 col;
      logic [31:0]        last;
      logic [31:0]        mag;
      logic               add;
      cdre_pkg::kind_type kind;
      n = active_columns();
      if (col_at >= n) col_at = 0;
      col = col_at;
      if (col == 0)
         raw_row = !is_primed || (model_cfg.refresh_interval != 0 &&
                                  delta_rows >= model_cfg.refresh_interval);
      add = 1'b0;
      mag = '0;
      if (raw_row) begin
         kind = cdre_pkg::KIND_RAW;
      end else begin
         last = prev_col[col];
         add = (v >= last);
         mag = add ? v - last : last - v;
         if (mag <= 32'(model_cfg.small_delta_max)) kind = cdre_pkg::KIND_SMALL;
         else if (mag <= 32'(model_cfg.medium_delta_max)) kind = cdre_pkg::KIND_MEDIUM;
         else kind = cdre_pkg::KIND_RAW;
      end
      case (kind)
         cdre_pkg::KIND_SMALL: begin
            coded = {16'h0, cdre_pkg::DELTA_MARK, add, cdre_pkg::SMALL_FORMAT, mag[12:0]};
            nbytes = 2;
         end
         cdre_pkg::KIND_MEDIUM: begin
            coded = {8'h0, cdre_pkg::DELTA_MARK, add, cdre_pkg::MEDIUM_FORMAT, mag[20:0]};
            nbytes = 3;
         end
         default: begin
            coded = {v[31:24] & cdre_pkg::RAW_TOP_MASK, v[23:0]};
            nbytes = 4;
         end
      endcase
      prev_col[col] = v;
      if (col + 1 >= n) begin
         if (raw_row) begin
            delta_rows = '0;
            is_primed = 1'b1;
         end else if (delta_rows != 16'hFFFF) begin
            delta_rows++;
         end
         col_at = 0;
      end else begin
         col_at = col + 1;
      end
   endfunction

   // random sample aimed at the coding thresholds of the next column
   function automatic logic [31:0] make_sample(input bit small_only);
      int          col;
      logic [31:0] last;
      logic [31:0] mag;
      int          pick;
      col = (col_at >= active_columns()) ? 0 : col_at;
      last = prev_col[col];
      pick = small_only ? 4 : $urandom_range(0, 9);
      case (pick)
         0: return $urandom();
         1: mag = '0;
         2: mag = 32'(model_cfg.small_delta_max) + $urandom_range(0, 2) - 32'd1;
         3: mag = 32'(model_cfg.medium_delta_max) + $urandom_range(0, 2) - 32'd1;
         4, 5: mag = $urandom_range(0, model_cfg.small_delta_max);
         6: mag = $urandom_range(model_cfg.small_delta_max, model_cfg.medium_delta_max);
         7: mag = $urandom();
         8: return last ^ (32'h1 << $urandom_range(0, 31));
         default: mag = $urandom_range(0, 255);
      endcase
      return $urandom_range(0, 1) ? last + mag : last - mag;
   endfunction

   task automatic send_sample(input logic [31:0] v, input int typed_bytes,
                              input logic [31:0] typed_code);
      logic [31:0] coded;
      int          nbytes;
      bit          took;
      encode_sample(v, coded, nbytes);
      if (typed_bytes != 0) begin
         coded = typed_code;
         nbytes = typed_bytes;
      end
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      for (int k = nbytes - 1; k >= 0; k--)
         bytes_due.push_back('{coded[8*k +: 8], k == 0});
   endtask

   task automatic write_register(input cdre_pkg::reg_index_type idx,
                                 input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] readback;
      bit          rdy;
      req_tvalid <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = csr_pready;
         @(posedge clock);
      end while (!rdy);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = csr_pready;
         readback = csr_prdata;
         @(posedge clock);
      end while (!rdy);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         cdre_pkg::REG_NUM_COLUMNS: begin
            mask = 32'h1F;
            model_cfg.num_columns = value[4:0];
         end
         cdre_pkg::REG_REFRESH_INTERVAL: begin
            mask = 32'hFFFF;
            model_cfg.refresh_interval = value[15:0];
         end
         cdre_pkg::REG_SMALL_DELTA_MAX: begin
            mask = 32'h1FFF;
            model_cfg.small_delta_max = value[12:0];
         end
         default: begin
            mask = 32'h1FFFFF;
            model_cfg.medium_delta_max = value[20:0];
         end
      endcase
      if (readback !== (value & mask)) begin
         mismatches++;
         $display("%0t: register %0d readback: expected %h, actual %h",
                  $time, idx, value & mask, readback);
      end
   endtask

   task automatic set_config(input logic [4:0] n, input logic [15:0] refresh,
                             input logic [12:0] small_max, input logic [20:0] medium_max);
      write_register(cdre_pkg::REG_NUM_COLUMNS, 32'(n));
      write_register(cdre_pkg::REG_REFRESH_INTERVAL, 32'(refresh));
      write_register(cdre_pkg::REG_SMALL_DELTA_MAX, 32'(small_max));
      write_register(cdre_pkg::REG_MEDIUM_DELTA_MAX, 32'(medium_max));
   endtask

   // first row is raw in all 16 columns, second row walks the delta extremes
   table_row_type directed [25] = '{
      '{32'h00000000, 4, 32'h00000000}, '{32'hFFFFFFFF, 4, 32'h7FFFFFFF},
      '{32'h80000000, 4, 32'h00000000}, '{32'h00010000, 4, 32'h00010000},
      '{32'h12345678, 4, 32'h12345678}, '{32'h40000000, 4, 32'h40000000},
      '{32'h7FFFFFFF, 4, 32'h7FFFFFFF}, '{32'hAAAAAAAA, 4, 32'h2AAAAAAA},
      '{32'h00000100, 4, 32'h00000100}, '{32'h5A5A5A5A, 4, 32'h5A5A5A5A},
      '{32'h00000001, 4, 32'h00000001}, '{32'hFEDCBA98, 4, 32'h7EDCBA98},
      '{32'h01234567, 4, 32'h01234567}, '{32'h0F0F0F0F, 4, 32'h0F0F0F0F},
      '{32'hF0F0F0F0, 4, 32'h70F0F0F0}, '{32'h80000001, 4, 32'h00000001},
      '{32'h00000000, 2, 32'h0000C000}, '{32'h00000000, 4, 32'h00000000},
      '{32'h80001FFF, 2, 32'h0000DFFF}, '{32'h0000E000, 3, 32'h00A02000},
      '{32'h12545677, 3, 32'h00FFFFFF}, '{32'h3FE00000, 4, 32'h3FE00000},
      '{32'h7FFFFFFE, 2, 32'h00008001}, '{32'h55555555, 0, 32'h0},
      '{32'h00000000, 2, 32'h00008100}
   };

   initial begin : receiver
      int gap;
      int holds_served;
      gap = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (long_hold_requests != holds_served) begin
            holds_served = long_hold_requests;
            gap = LONG_HOLD;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            gap--;
         end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            gap = $urandom_range(1, 9) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : byte_check
      coded_byte_type want;
      forever begin
         @(negedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (bytes_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected byte: expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = bytes_due.pop_front();
               if (rsp_tdata !== want.value || rsp_tlast !== want.last) begin
                  mismatches++;
                  $display("%0t: byte mismatch: expected %h last %b, actual %h last %b",
                           $time, want.value, want.last, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(negedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      logic [4:0]  n;
      logic [15:0] refresh;
      logic [12:0] small_max;
      logic [20:0] medium_max;
      foreach (prev_col[i]) prev_col[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // all columns must be written by the first raw row
      write_register(cdre_pkg::REG_NUM_COLUMNS, 32'd16);
      foreach (directed[i])
         send_sample(directed[i].sample, directed[i].nbytes, directed[i].coded);

      for (int p = 0; p < 8; p++) begin
         tx_idle_on = 1'b1;
         rx_idle_on = 1'b1;
         case (p)
            0: set_config(5'd3, 16'd2, 13'd8191, 21'd2097151);
            1: set_config(5'd0, 16'd1, 13'd0, 21'd0);
            2: begin
               tx_idle_on = 1'b0;
               set_config(5'd31, 16'd0, 13'd100, 21'd5000);
            end
            3: set_config(5'd5, 16'd3, 13'd8191, 21'd0);
            4: begin
               tx_idle_on = 1'b0;
               rx_idle_on = 1'b0;
               set_config(5'd16, 16'd65535, 13'd255, 21'd65535);
            end
            7: set_config(5'd2, 16'd1, 13'd8191, 21'd2097151);
            default: begin
               n = $urandom_range(0, 31);
               refresh = $urandom_range(0, 4);
               small_max = $urandom_range(0, 8191);
               medium_max = $urandom_range(0, 2097151);
               set_config(n, refresh, small_max, medium_max);
            end
         endcase
         if (p == 2) long_hold_requests++;
         repeat (PHASE_WORDS) send_sample(make_sample(1'b0), 0, '0);
      end

      // closing stretch without idle cycles
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      set_config(5'd4, 16'd2, 13'd8191, 21'd2097151);
      repeat (FINAL_WORDS) send_sample(make_sample(1'b0), 0, '0);

      req_tvalid <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cdre_pkg.sv
rtl/cdre_csr.sv
rtl/cdre_front.sv
rtl/cdre_fifo.sv
rtl/cdre_back.sv
rtl/column_delta_row_encoder.sv
bench/tb_column_delta_row_encoder.sv
